// File: design/frss_pkg.sv
// ----------------------------------------------------------------------------
// frss_pkg
// Shared sizes, operation and status codes and helpers for the rank store.
// ----------------------------------------------------------------------------
`default_nettype none

package frss_pkg;

    localparam int SLOTS   = 1024;
    localparam int FIELD_W = 11;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;

    // tree counts and slot positions run 0..SLOTS
    localparam int PW  = $clog2(SLOTS + 1);
    localparam int AW  = $clog2(SLOTS);
    // largest power of two not above SLOTS
    localparam int TOP = 1 << (PW - 1);

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_PREFIX = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_RANK = 2'd2;

    typedef logic [PW-1:0] t_count;
    typedef logic [AW-1:0] t_addr;

    // lowest set bit of a tree position
    function automatic t_count low_bit(input t_count v);
        return v & (~v + t_count'(1));
    endfunction

endpackage

`default_nettype wire

// File: design/fenwick_rank_sequence_store.sv
// append, read and delete by rank and prefix walk the tree, with log2(SLOTS) + 1 levels (11);
// clear runs a clearing pass; a bad rank, a full store and unused codes answer from idle
// one request at a time; the walk through the tree memory, one entry a cycle, sets the rate
// synchronous reset starts a clearing pass over every tree memory entry with busy high
// the result is shown for one cycle on o_done and the receiver cannot stall it
// ----------------------------------------------------------------------------
// fenwick_rank_sequence_store
// Order-statistic store of one-bit elements over a Fenwick tree of live
// counts held in a synchronous memory; append, delete, read, prefix, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_rank_sequence_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [frss_pkg::OP_W-1:0]    i_op,
    input  wire logic                         i_bit_value,
    input  wire logic [frss_pkg::FIELD_W-1:0] i_rank,
    input  wire logic [frss_pkg::FIELD_W-1:0] i_slot,
    output logic                              o_done,
    output logic [frss_pkg::ST_W-1:0]         o_status,
    output logic [frss_pkg::FIELD_W-1:0]      o_found_slot,
    output logic                              o_read_bit,
    output logic [frss_pkg::FIELD_W-1:0]      o_prefix_count,
    output logic [frss_pkg::FIELD_W-1:0]      o_live_total
);
    import frss_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_PRE  = 3'd4;
    localparam logic [2:0] S_BIT  = 3'd5;

    localparam t_count      SLOTS_C = t_count'(SLOTS);
    localparam logic [PW:0] SLOTS_X = (PW + 1)'(SLOTS);
    localparam t_count      TOP_C   = t_count'(TOP);
    localparam t_addr       LAST_A  = t_addr'(SLOTS - 1);

    // memories
    t_count r_tree_mem [SLOTS];
    t_count r_tree_q;
    logic   r_bit_mem [SLOTS];
    logic   r_bit_q;

    logic   tree_we;
    t_addr  tree_waddr;
    t_count tree_wdata;
    t_addr  tree_raddr;
    logic   bit_we;
    t_addr  bit_waddr;
    t_addr  bit_raddr;

    // control
    logic [2:0] r_state, n_state;
    t_addr      r_clr_addr, n_clr_addr;
    logic       r_clr_reply, n_clr_reply;
    t_count     r_used, n_used;
    t_count     r_live, n_live;
    logic       r_done, n_done;

    // walk registers
    t_count r_pos, n_pos;
    t_count r_next, n_next;
    t_count r_step, n_step;
    t_count r_want, n_want;
    t_count r_sum, n_sum;
    t_count r_found, n_found;
    logic   r_rd_ok, n_rd_ok;
    logic   r_up, n_up;
    logic   r_read_op, n_read_op;

    // result registers
    logic [ST_W-1:0] r_status, n_status;
    t_count          r_out_found, n_out_found;
    logic            r_out_bit, n_out_bit;
    t_count          r_out_prefix, n_out_prefix;

    // rank search step
    logic        f_take;
    t_count      f_pos;
    t_count      f_want;
    t_count      f_step;
    logic [PW:0] f_next_w;
    logic [PW:0] f_addr_w;
    logic        f_ok;
    t_count      f_found;
    t_count      f_found_m1;

    // tree update and prefix steps
    logic [PW:0] u_next_w;
    logic [PW:0] u_addr_w;
    t_count      pos_m1;
    t_count      p_sum;
    t_count      p_next;
    t_count      p_addr;

    // request side
    logic   accept;
    t_count req_slot;
    t_count req_slot_m1;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        f_take     = r_rd_ok && (r_tree_q < r_want);
        f_pos      = f_take ? r_next : r_pos;
        f_want     = f_take ? (r_want - r_tree_q) : r_want;
        f_step     = r_step >> 1;
        f_next_w   = {1'b0, f_pos} + {1'b0, f_step};
        f_addr_w   = f_next_w - (PW + 1)'(1);
        f_ok       = (f_next_w <= SLOTS_X);
        f_found    = (f_pos >= SLOTS_C) ? SLOTS_C : (f_pos + t_count'(1));
        f_found_m1 = f_found - t_count'(1);

        u_next_w = {1'b0, r_pos} + {1'b0, low_bit(r_pos)};
        u_addr_w = u_next_w - (PW + 1)'(1);
        pos_m1   = r_pos - t_count'(1);
        p_sum    = r_sum + r_tree_q;
        p_next   = r_pos - low_bit(r_pos);
        p_addr   = p_next - t_count'(1);

        // slots above the store are saturated
        req_slot    = (32'(i_slot) > SLOTS) ? SLOTS_C : t_count'(i_slot);
        req_slot_m1 = req_slot - t_count'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_clr_reply  = r_clr_reply;
        n_used       = r_used;
        n_live       = r_live;
        n_pos        = r_pos;
        n_next       = r_next;
        n_step       = r_step;
        n_want       = r_want;
        n_sum        = r_sum;
        n_found      = r_found;
        n_rd_ok      = r_rd_ok;
        n_up         = r_up;
        n_read_op    = r_read_op;
        n_done       = 1'b0;
        n_status     = ST_OK;
        n_out_found  = '0;
        n_out_bit    = 1'b0;
        n_out_prefix = '0;
        tree_we      = 1'b0;
        tree_waddr   = '0;
        tree_wdata   = '0;
        tree_raddr   = '0;
        bit_we       = 1'b0;
        bit_waddr    = '0;
        bit_raddr    = '0;

        case (r_state)
            S_INIT: begin
                tree_we    = 1'b1;
                tree_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + t_addr'(1);
                if (r_clr_addr == LAST_A) begin
                    n_state     = S_IDLE;
                    n_done      = r_clr_reply;
                    n_clr_reply = 1'b0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_APPEND: begin
                            if (r_used >= SLOTS_C) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_used     = r_used + t_count'(1);
                                n_live     = r_live + t_count'(1);
                                n_found    = r_used + t_count'(1);
                                n_pos      = r_used + t_count'(1);
                                n_up       = 1'b1;
                                bit_we     = 1'b1;
                                bit_waddr  = r_used[AW-1:0];
                                tree_raddr = r_used[AW-1:0];
                                n_state    = S_UPD;
                            end
                        end
                        OP_DELETE, OP_READ: begin
                            if (i_rank == '0 || 32'(i_rank) > 32'(r_live)) begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_RANK;
                            end else begin
                                n_want     = t_count'(i_rank);
                                n_pos      = '0;
                                n_step     = TOP_C;
                                n_next     = TOP_C;
                                n_rd_ok    = 1'b1;
                                n_read_op  = (i_op == OP_READ);
                                tree_raddr = t_addr'(TOP - 1);
                                n_state    = S_FIND;
                            end
                        end
                        OP_PREFIX: begin
                            if (req_slot == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_pos      = req_slot;
                                n_sum      = '0;
                                tree_raddr = req_slot_m1[AW-1:0];
                                n_state    = S_PRE;
                            end
                        end
                        OP_CLEAR: begin
                            n_used      = '0;
                            n_live      = '0;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_INIT;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_FIND: begin
                // descend one tree level per cycle, read data is for r_next
                if (f_step == '0) begin
                    n_found = f_found;
                    if (r_read_op) begin
                        bit_raddr = f_found_m1[AW-1:0];
                        n_state   = S_BIT;
                    end else begin
                        n_live     = r_live - t_count'(1);
                        n_pos      = f_found;
                        n_up       = 1'b0;
                        tree_raddr = f_found_m1[AW-1:0];
                        n_state    = S_UPD;
                    end
                end else begin
                    n_pos      = f_pos;
                    n_want     = f_want;
                    n_step     = f_step;
                    n_next     = f_next_w[PW-1:0];
                    n_rd_ok    = f_ok;
                    tree_raddr = f_addr_w[AW-1:0];
                end
            end
            S_UPD: begin
                // write back this level and read the next one, always a higher entry
                tree_we    = 1'b1;
                tree_waddr = pos_m1[AW-1:0];
                tree_wdata = r_up ? (r_tree_q + t_count'(1)) : (r_tree_q - t_count'(1));
                if (u_next_w > SLOTS_X) begin
                    n_done      = 1'b1;
                    n_out_found = r_found;
                    n_state     = S_IDLE;
                end else begin
                    n_pos      = u_next_w[PW-1:0];
                    tree_raddr = u_addr_w[AW-1:0];
                end
            end
            S_PRE: begin
                n_sum = p_sum;
                if (p_next == '0) begin
                    n_done       = 1'b1;
                    n_out_prefix = p_sum;
                    n_state      = S_IDLE;
                end else begin
                    n_pos      = p_next;
                    tree_raddr = p_addr[AW-1:0];
                end
            end
            S_BIT: begin
                n_done      = 1'b1;
                n_out_found = r_found;
                n_out_bit   = r_bit_q;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_used      <= '0;
            r_live      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_used      <= n_used;
            r_live      <= n_live;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_next       <= n_next;
        r_step       <= n_step;
        r_want       <= n_want;
        r_sum        <= n_sum;
        r_found      <= n_found;
        r_rd_ok      <= n_rd_ok;
        r_up         <= n_up;
        r_read_op    <= n_read_op;
        r_status     <= n_status;
        r_out_found  <= n_out_found;
        r_out_bit    <= n_out_bit;
        r_out_prefix <= n_out_prefix;
    end

    // tree counts: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tree_we) begin
            r_tree_mem[tree_waddr] <= tree_wdata;
        end
        r_tree_q <= r_tree_mem[tree_raddr];
    end

    // element bits, never cleared
    always_ff @(posedge i_clk) begin
        if (bit_we) begin
            r_bit_mem[bit_waddr] <= i_bit_value;
        end
        r_bit_q <= r_bit_mem[bit_raddr];
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_found_slot   = FIELD_W'(r_out_found);
    assign o_read_bit     = r_out_bit;
    assign o_prefix_count = FIELD_W'(r_out_prefix);
    assign o_live_total   = FIELD_W'(r_live);

endmodule

`default_nettype wire

// File: design/frss_checker.sv
// ----------------------------------------------------------------------------
// frss_checker
// Port-level checks on the rank store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frss_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_done,
    input wire logic [frss_pkg::ST_W-1:0]    o_status,
    input wire logic [frss_pkg::FIELD_W-1:0] o_found_slot,
    input wire logic                         o_read_bit,
    input wire logic [frss_pkg::FIELD_W-1:0] o_prefix_count,
    input wire logic [frss_pkg::FIELD_W-1:0] o_live_total
);
    import frss_pkg::*;

    // a result only follows a request or work in progress
    a_reply_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result strobe without a request");

    // an accepted request either keeps the block busy or answers at once
    a_request_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("request dropped");

    // an error result carries no located slot, bit or count
    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |->
            (o_found_slot == '0 && !o_read_bit && o_prefix_count == '0))
        else $error("error result with payload");

    a_live_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_live_total) <= SLOTS && 32'(o_found_slot) <= SLOTS))
        else $error("live total or slot out of range");

endmodule

bind fenwick_rank_sequence_store frss_checker u_frss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_found_slot   (o_found_slot),
    .o_read_bit     (o_read_bit),
    .o_prefix_count (o_prefix_count),
    .o_live_total   (o_live_total)
);

`default_nettype wire
